FILE: design/als_pkg.sv
// Shared types and constants for the activity lamp and power sequencer.
package als_pkg;

  // Lamp count is fixed by the 4-bit lamp mask: tx and rx lamp per channel.
  localparam int unsigned LampCount = 4;

  // Register reset values.
  localparam logic [15:0] HoldReset   = 16'd50;
  localparam logic [15:0] SettleReset = 16'd4;
  localparam logic [15:0] PollReset   = 16'd10;

  // Event codes; the two remaining codes change nothing.
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_TX_START = 3'd1,
    OP_TX_DONE  = 3'd2,
    OP_RX       = 3'd3,
    OP_BUS_STOP = 3'd4,
    OP_REBOOT   = 3'd5
  } op_e;

  // Configuration register indexes; the fourth index writes nothing.
  typedef enum logic [1:0] {
    CFG_HOLD   = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_POLL   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  channel;
    logic [15:0] rx_bytes;
    logic        host_configured;
  } in_t;

  typedef struct packed {
    logic [3:0] lamp_mask;
    logic       lamps_enabled;
    logic       power_on;
    logic       target_ready;
  } out_t;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] poll_ticks;
  } cfg_t;

endpackage

FILE: design/activity_lamp_power_sequencer.sv
// Activity lamp and target power sequencer: one status transfer out per event transfer in.
// Takes one event per clock while the output is not stalled, and returns one status word
// for each: an input register feeds a combinational state update whose outputs land in
// an output register. With the output side never stalling, the sustained rate is one
// event per cycle; a stall on the output holds one status word and one waiting event,
// after which in_stall_o is raised. Configuration writes take effect on the next event.
module activity_lamp_power_sequencer #(
  parameter int unsigned CHANNELS  = 2,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  als_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output als_pkg::out_t out_data_o
);

  als_pkg::cfg_t cfg;
  als_pkg::in_t  in_q;
  als_pkg::out_t out_q;
  als_pkg::out_t result;
  logic          in_vld_q;
  logic          out_vld_q;
  logic          out_free;
  logic          step;
  logic          in_take;

  als_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  als_core #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Pipeline flow control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture the event and the status word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/als_cfg.sv
// Configuration registers: hold, settle and poll periods in ticks.
module als_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output als_pkg::cfg_t     cfg_o
);

  als_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (als_pkg::cfg_idx_e'(cfg_index_i))
        als_pkg::CFG_HOLD:   cfg_d.hold_ticks   = cfg_data_i;
        als_pkg::CFG_SETTLE: cfg_d.settle_ticks = cfg_data_i;
        als_pkg::CFG_POLL:   cfg_d.poll_ticks   = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks   <= als_pkg::HoldReset;
      cfg_q.settle_ticks <= als_pkg::SettleReset;
      cfg_q.poll_ticks   <= als_pkg::PollReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/als_core.sv
// Sequencer state and the combinational update for one event.
module als_core #(
  parameter int unsigned CHANNELS  = 2,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  als_pkg::in_t  item_i,
  input  als_pkg::cfg_t cfg_i,
  output als_pkg::out_t result_o
);

  localparam logic [2:0] ChanLimit = 3'(CHANNELS);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic [15:0]          poll_q, poll_d;
  logic [TIME_BITS-1:0] last_q [als_pkg::LampCount];
  logic [TIME_BITS-1:0] last_d [als_pkg::LampCount];
  logic [3:0]           valid_q, valid_d;
  logic [3:0]           infl_q, infl_d;
  logic                 pwr_q, pwr_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic                 ready_q, ready_d;
  logic                 reboot_q, reboot_d;
  logic [3:0]           mask_q, mask_d;
  logic                 en_q, en_d;

  logic [TIME_BITS-1:0] tick_time;
  logic [TIME_BITS-1:0] settle_el;
  logic [TIME_BITS-1:0] hold_ext;
  logic [TIME_BITS-1:0] settle_ext;
  logic [TIME_BITS-1:0] lamp_el [als_pkg::LampCount];
  logic [15:0]          poll_inc;
  logic [3:0]           lit;
  logic                 eval_run;
  logic                 ready_eval;
  logic                 host_ok;
  logic                 allowed;
  logic                 ch_ok;
  logic [1:0]           tx_idx;
  logic [1:0]           rx_idx;

  // Timing compares, all against the time or poll count after this tick
  always_comb begin
    tick_time  = time_q + TIME_BITS'(1);
    poll_inc   = poll_q + 16'd1;
    eval_run   = (poll_inc >= cfg_i.poll_ticks);
    hold_ext   = TIME_BITS'(cfg_i.hold_ticks);
    settle_ext = TIME_BITS'(cfg_i.settle_ticks);
    settle_el  = tick_time - start_q;
    ready_eval = pwr_q && (ready_q || (settle_el >= settle_ext));
    for (int i = 0; i < als_pkg::LampCount; i++) begin
      lamp_el[i] = tick_time - last_q[i];
      lit[i]     = infl_q[i] || (valid_q[i] && (lamp_el[i] < hold_ext));
    end
  end

  // Event qualifiers
  always_comb begin
    host_ok = item_i.host_configured;
    allowed = ready_q && host_ok && !reboot_q;
    ch_ok   = ({1'b0, item_i.channel} < ChanLimit);
    tx_idx  = {item_i.channel[0], 1'b0};
    rx_idx  = {item_i.channel[0], 1'b1};
  end

  // Next state for one event
  always_comb begin
    time_d   = time_q;
    poll_d   = poll_q;
    last_d   = last_q;
    valid_d  = valid_q;
    infl_d   = infl_q;
    pwr_d    = pwr_q;
    start_d  = start_q;
    ready_d  = ready_q;
    reboot_d = reboot_q;
    mask_d   = mask_q;
    en_d     = en_q;
    case (als_pkg::op_e'(item_i.opcode))
      als_pkg::OP_TICK: begin
        time_d = tick_time;
        poll_d = eval_run ? 16'd0 : poll_inc;
        if (eval_run) begin
          if (!host_ok || reboot_q) begin
            pwr_d   = 1'b0;
            ready_d = 1'b0;
            valid_d = '0;
            infl_d  = '0;
            mask_d  = '0;
            en_d    = 1'b0;
          end else begin
            // Request power first; declare ready on a later poll
            pwr_d   = 1'b1;
            if (!pwr_q) begin
              start_d = tick_time;
            end
            ready_d = ready_eval;
            if (ready_eval) begin
              mask_d  = lit;
              valid_d = valid_q & lit;
            end else begin
              mask_d  = '0;
            end
            en_d    = 1'b1;
          end
        end
      end
      als_pkg::OP_TX_START: begin
        if (ch_ok && allowed) begin
          infl_d[tx_idx]  = 1'b1;
          valid_d[tx_idx] = 1'b1;
          last_d[tx_idx]  = time_q;
        end
      end
      als_pkg::OP_TX_DONE: begin
        if (ch_ok && infl_q[tx_idx]) begin
          infl_d[tx_idx] = 1'b0;
          last_d[tx_idx] = time_q;
        end
      end
      als_pkg::OP_RX: begin
        if (ch_ok && (item_i.rx_bytes != 16'd0) && allowed) begin
          valid_d[rx_idx] = 1'b1;
          last_d[rx_idx]  = time_q;
        end
      end
      als_pkg::OP_BUS_STOP, als_pkg::OP_REBOOT: begin
        if (als_pkg::op_e'(item_i.opcode) == als_pkg::OP_REBOOT) begin
          reboot_d = 1'b1;
        end
        pwr_d   = 1'b0;
        ready_d = 1'b0;
        valid_d = '0;
        infl_d  = '0;
        mask_d  = '0;
        en_d    = 1'b0;
      end
      default: begin
        time_d = time_q;
      end
    endcase
  end

  // Hold state; advance only on a processed event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      poll_q   <= '0;
      valid_q  <= '0;
      infl_q   <= '0;
      pwr_q    <= 1'b0;
      ready_q  <= 1'b0;
      reboot_q <= 1'b0;
      mask_q   <= '0;
      en_q     <= 1'b0;
    end else if (step_i) begin
      time_q   <= time_d;
      poll_q   <= poll_d;
      valid_q  <= valid_d;
      infl_q   <= infl_d;
      pwr_q    <= pwr_d;
      ready_q  <= ready_d;
      reboot_q <= reboot_d;
      mask_q   <= mask_d;
      en_q     <= en_d;
    end
  end

  // Timestamps are read only behind their valid or request flags
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      last_q  <= last_d;
      start_q <= start_d;
    end
  end

  assign result_o.lamp_mask     = mask_d;
  assign result_o.lamps_enabled = en_d;
  assign result_o.power_on      = pwr_d;
  assign result_o.target_ready  = ready_d;

endmodule

FILE: design/als_checker.sv
// Port-level checks for the activity lamp and power sequencer, bound to the top level.
module als_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input als_pkg::out_t out_data_o
);

  // A stalled status transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("status changed while stalled");

  // Input side stalls only behind a stalled full output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Power request and lamp driver enable rise and drop together
  a_pwr_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.power_on == out_data_o.lamps_enabled))
    else $error("power request and lamp enable disagree");

  // Ready only while power is requested
  a_ready_pwr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.target_ready |-> out_data_o.power_on)
    else $error("target ready without power request");

  // Lamps light only once the target is ready
  a_mask_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.lamp_mask != 4'd0) |-> out_data_o.target_ready)
    else $error("lamp lit before target ready");

endmodule

bind activity_lamp_power_sequencer als_checker u_als_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
